>>> rtl/hbw_pkg.sv
// Heartbeat watchdog package: shared constants, codes and structs.
// No dependencies; used by every file in rtl.
package hbw_pkg;

    localparam int CHANNEL_COUNT_DEF = 4;

    localparam int TIMEOUT_W = 20;
    localparam int PERIOD_W  = 16;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5000);
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BEAT  = 2'd1;
    localparam logic [1:0] OP_FAULT = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FAULT = 2'd1;
    localparam logic [1:0] KIND_STALL = 2'd2;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout;
        logic [PERIOD_W-1:0]  period;
    } cfg_t;

    typedef struct packed {
        logic               request;
        logic [1:0]         kind;
        logic [7:0]         value;
        logic [COUNT_W-1:0] total;
    } res_t;

endpackage

>>> rtl/multi_channel_heartbeat_watchdog.sv
// Multi-channel heartbeat watchdog top level: configuration registers,
// output register, sequencer and beat memory. Depends on hbw_pkg, hbw_core, hbw_beat_mem.
//
//   Channel   Signals                    Contents
//   input     s_tvalid/s_tready          tuser: operation; tdata: channel, fault_code
//   output    m_tvalid/m_tready          tuser: reset_request, cause_kind;
//                                        tdata: cause_value, reset_total
//   config    cfg_we/cfg_index/cfg_wdata 0 timeout_ticks, 1 check_period
//
// Beat, fault and clear transactions and a tick without a scan go from idle straight
// to the done state; a scanning tick does one memory read and one age compare per
// channel, stopping at the first stale one. One transaction is in the sequencer at a time.
// The output register lets the next transaction start while a result waits.
// Reset is asynchronous and needs no clearing pass; seen bits clear at once.
module multi_channel_heartbeat_watchdog #(
    parameter int CHANNEL_COUNT = hbw_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // channel[7:0], fault_code[15:8]
    input  logic [1:0]                    s_tuser,   // operation[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // cause_value[7:0], reset_total[39:8]
    output logic [2:0]                    m_tuser,   // reset_request[0], cause_kind[2:1]
    input  logic                          cfg_we,
    input  logic [hbw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbw_pkg::TIMEOUT_W-1:0] cfg_wdata
);

    localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    hbw_pkg::cfg_t              cfg_reg;
    hbw_pkg::res_t              res;
    hbw_pkg::res_t              out_reg;
    logic                       out_valid_reg;
    logic                       res_valid;
    logic                       res_ready;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [hbw_pkg::TIME_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [hbw_pkg::TIME_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout <= hbw_pkg::TIMEOUT_RESET;
            cfg_reg.period  <= hbw_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hbw_pkg::CFG_TIMEOUT: cfg_reg.timeout <= cfg_wdata;
                hbw_pkg::CFG_PERIOD:  cfg_reg.period  <= cfg_wdata[hbw_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.total, out_reg.value};
    assign m_tuser  = {out_reg.kind, out_reg.request};

    hbw_core #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_channel(s_tdata[7:0]),
        .in_code   (s_tdata[15:8]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    hbw_beat_mem #(
        .DEPTH(CHANNEL_COUNT)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // sequencer leaves idle on every accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    a_request_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] != hbw_pkg::KIND_NONE))
        else $error("reset request without a latched cause");

    a_request_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[39:8] != '0))
        else $error("reset request with zero reset total");

endmodule

>>> rtl/hbw_beat_mem.sv
// Beat timestamp memory: one write port, one read port, registered read data.
// Depends on hbw_pkg.
module hbw_beat_mem #(
    parameter int DEPTH = hbw_pkg::CHANNEL_COUNT_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [hbw_pkg::TIME_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [hbw_pkg::TIME_W-1:0] rdata
);

    logic [hbw_pkg::TIME_W-1:0] mem [DEPTH];
    logic [hbw_pkg::TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hbw_core.sv
// Watchdog sequencer: tick time, scan countdown, seen bits, cause and count.
// Scans the beat memory one channel at a time, through a read and a compare state. Depends on hbw_pkg.
module hbw_core #(
    parameter int CHANNEL_COUNT = hbw_pkg::CHANNEL_COUNT_DEF,
    localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hbw_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_op,
    input  logic [7:0]                 in_channel,
    input  logic [7:0]                 in_code,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [hbw_pkg::TIME_W-1:0] mem_wdata,
    output logic [AW-1:0]              mem_raddr,
    input  logic [hbw_pkg::TIME_W-1:0] mem_rdata,
    output logic                       res_valid,
    input  logic                       res_ready,
    output hbw_pkg::res_t              res
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CMP, ST_DONE} state_t;

    state_t                         state_reg, state_next;
    logic [hbw_pkg::TIME_W-1:0]     tick_reg, tick_next;
    logic [hbw_pkg::PERIOD_W-1:0]   cnt_reg, cnt_next;
    logic [CHANNEL_COUNT-1:0]       seen_reg, seen_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [hbw_pkg::COUNT_W-1:0]    total_reg, total_next;
    logic [1:0]                     kind_reg, kind_next;
    logic [7:0]                     value_reg, value_next;
    logic                           req_reg, req_next;

    logic                           accept;
    logic                           in_range;
    logic [hbw_pkg::TIME_W-1:0]     age;
    logic                           stale;
    logic [hbw_pkg::PERIOD_W-1:0]   period_eff;
    logic [hbw_pkg::COUNT_W-1:0]    total_inc;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign in_range   = ({1'b0, in_channel} < 9'(CHANNEL_COUNT));
    assign age        = tick_reg - mem_rdata;
    assign stale      = seen_reg[idx_reg]
                        && (age > {{(hbw_pkg::TIME_W-hbw_pkg::TIMEOUT_W){1'b0}}, cfg.timeout});
    assign period_eff = (cfg.period == '0) ? hbw_pkg::PERIOD_W'(1) : cfg.period;
    assign total_inc  = (total_reg == '1) ? total_reg : total_reg + 1'b1;

    assign mem_we    = accept && (in_op == hbw_pkg::OP_BEAT) && in_range;
    assign mem_waddr = in_channel[AW-1:0];
    assign mem_wdata = tick_reg;
    assign mem_raddr = idx_reg;

    assign res_valid     = (state_reg == ST_DONE);
    assign res.request   = req_reg;
    assign res.kind      = kind_reg;
    assign res.value     = value_reg;
    assign res.total     = total_reg;

    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        cnt_next   = cnt_reg;
        seen_next  = seen_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        req_next   = req_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = 1'b0;
                    state_next = ST_DONE;
                    case (in_op)
                        hbw_pkg::OP_TICK:
                        begin
                            tick_next = tick_reg + 1'b1;
                            if (cnt_reg == '0)
                            begin
                                cnt_next   = period_eff - 1'b1;
                                idx_next   = '0;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        hbw_pkg::OP_BEAT:
                        begin
                            if (in_range)
                            begin
                                seen_next[in_channel[AW-1:0]] = 1'b1;
                            end
                        end
                        hbw_pkg::OP_FAULT:
                        begin
                            req_next   = 1'b1;
                            total_next = total_inc;
                            kind_next  = hbw_pkg::KIND_FAULT;
                            value_next = in_code;
                            seen_next  = '0;
                        end
                        default:
                        begin
                            total_next = '0;
                            kind_next  = hbw_pkg::KIND_NONE;
                            value_next = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stale)
                begin
                    req_next   = 1'b1;
                    total_next = total_inc;
                    kind_next  = hbw_pkg::KIND_STALL;
                    value_next = 8'(idx_reg);
                    seen_next  = '0;
                    state_next = ST_DONE;
                end
                else if (idx_reg == AW'(CHANNEL_COUNT - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            cnt_reg   <= '0;
            seen_reg  <= '0;
            idx_reg   <= '0;
            total_reg <= '0;
            kind_reg  <= hbw_pkg::KIND_NONE;
            value_reg <= '0;
            req_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            kind_reg  <= kind_next;
            value_reg <= value_next;
            req_reg   <= req_next;
        end
    end

endmodule

>>> tb/hbw_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the heartbeat watchdog. It follows the input, output and register
// ports, predicts each result and compares it field by field. Depends on hbw_pkg.
module hbw_checker #(
    parameter int CH_COUNT = hbw_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // channel[7:0], fault_code[15:8]
    input  logic [1:0]                    s_tuser,   // operation[1:0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [39:0]                   m_tdata,   // cause_value[7:0], reset_total[39:8]
    input  logic [2:0]                    m_tuser,   // reset_request[0], cause_kind[2:1]
    input  logic                          cfg_we,
    input  logic [hbw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbw_pkg::TIMEOUT_W-1:0] cfg_wdata,
    output int                            errors,
    output int                            outstanding
);
    import hbw_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_q;
    logic [PERIOD_W-1:0]  period_q;
    logic [TIME_W-1:0]    last_beat [CH_COUNT];
    logic                 seen [CH_COUNT];
    logic [TIME_W-1:0]    now_q;
    logic [PERIOD_W-1:0]  countdown_q;
    logic [COUNT_W-1:0]   total_q;
    logic [1:0]           kind_q;
    logic [7:0]           value_q;
    res_t                 awaited_res[$];
    int                   err_count;

    function automatic void latch_request(input logic [1:0] kind, input logic [7:0] value);
        if (total_q != '1)
            total_q++;
        kind_q  = kind;
        value_q = value;
        for (int i = 0; i < CH_COUNT; i++)
        begin
            last_beat[i] = '0;
            seen[i]      = 1'b0;
        end
    endfunction

    function automatic res_t watchdog_next(input logic [1:0] op, input logic [7:0] chan,
                                           input logic [7:0] code);
        res_t                r;
        logic                hit;
        logic [PERIOD_W-1:0] span;
        hit = 1'b0;
        case (op)
            OP_TICK:
            begin
                now_q++;
                if (countdown_q == '0)
                begin
                    span        = (period_q == '0) ? PERIOD_W'(1) : period_q;
                    countdown_q = span - PERIOD_W'(1);
                    // lowest stalled channel wins; the table is cleared after it
                    for (int i = 0; i < CH_COUNT; i++)
                    begin
                        if (!hit && seen[i] && (now_q - last_beat[i]) > TIME_W'(timeout_q))
                        begin
                            latch_request(KIND_STALL, 8'(i));
                            hit = 1'b1;
                        end
                    end
                end
                else
                    countdown_q--;
            end
            OP_BEAT:
            begin
                if (chan < CH_COUNT)
                begin
                    last_beat[chan] = now_q;
                    seen[chan]      = 1'b1;
                end
            end
            OP_FAULT:
            begin
                latch_request(KIND_FAULT, code);
                hit = 1'b1;
            end
            OP_CLEAR:
            begin
                total_q = '0;
                kind_q  = KIND_NONE;
                value_q = '0;
            end
        endcase
        r.request = hit;
        r.kind    = kind_q;
        r.value   = value_q;
        r.total   = total_q;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        res_t want;
        logic bad;
        if (!rst_n)
        begin
            timeout_q   = TIMEOUT_RESET;
            period_q    = PERIOD_RESET;
            now_q       = '0;
            countdown_q = '0;
            total_q     = '0;
            kind_q      = KIND_NONE;
            value_q     = '0;
            for (int i = 0; i < CH_COUNT; i++)
            begin
                last_beat[i] = '0;
                seen[i]      = 1'b0;
            end
            awaited_res.delete();
            err_count   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_res.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tuser %h tdata %h",
                             $time, m_tuser, m_tdata);
                    err_count++;
                end
                else
                begin
                    want = awaited_res.pop_front();
                    bad  = 1'b0;
                    if (m_tuser[0] !== want.request)
                    begin
                        $display("%0t: reset_request expected %h actual %h",
                                 $time, want.request, m_tuser[0]);
                        bad = 1'b1;
                    end
                    if (m_tuser[2:1] !== want.kind)
                    begin
                        $display("%0t: cause_kind expected %h actual %h",
                                 $time, want.kind, m_tuser[2:1]);
                        bad = 1'b1;
                    end
                    if (m_tdata[7:0] !== want.value)
                    begin
                        $display("%0t: cause_value expected %h actual %h",
                                 $time, want.value, m_tdata[7:0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[39:8] !== want.total)
                    begin
                        $display("%0t: reset_total expected %h actual %h",
                                 $time, want.total, m_tdata[39:8]);
                        bad = 1'b1;
                    end
                    if (bad)
                        err_count++;
                end
            end
            if (s_tvalid && s_tready)
                awaited_res.push_back(watchdog_next(s_tuser, s_tdata[7:0], s_tdata[15:8]));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_q = cfg_wdata;
                    CFG_PERIOD:  period_q  = cfg_wdata[PERIOD_W-1:0];
                    default:     ;
                endcase
            end
        end
        errors      <= err_count;
        outstanding <= awaited_res.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the heartbeat watchdog testbench: clock, reset, stimulus and verdict.
// Depends on hbw_pkg, hbw_checker and the multi_channel_heartbeat_watchdog RTL.
module tb;
    import hbw_pkg::*;

    localparam int NCH         = CHANNEL_COUNT_DEF;
    localparam int SETTLE      = 2 * NCH + 8;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIMEOUT_W-1:0] cfg_wdata;
    int                   errors;
    int                   outstanding;
    logic                 tx_idle_on;
    logic                 rx_idle_on;
    logic                 rx_hold;
    int                   sent_count;
    int                   drain_fail;
    int                   setting_count;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multi_channel_heartbeat_watchdog #(.CHANNEL_COUNT(NCH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    hbw_checker #(.CH_COUNT(NCH)) scoreboard (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .outstanding(outstanding)
    );

    // result side: random back-pressure bursts, plus one long hold on request
    initial
    begin : rx_side
        logic hold_done;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] chan,
                             input logic [7:0] code);
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {code, chan};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_random();
        int         pick;
        logic [1:0] op;
        logic [7:0] chan;
        pick = $urandom_range(0, 99);
        op   = (pick < 50) ? OP_TICK : (pick < 85) ? OP_BEAT : (pick < 93) ? OP_FAULT : OP_CLEAR;
        chan = 8'($urandom_range(0, 255));
        if (op == OP_BEAT && $urandom_range(0, 4) != 0)
            chan = 8'($urandom_range(0, NCH - 1));
        send_item(op, chan, 8'($urandom_range(0, 255)));
    endtask

    // stop offering, wait for every outstanding result, then let the block settle
    task automatic drain();
        int waited;
        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (outstanding != 0)
        begin
            $display("%0t: results expected %0d actual 0 (never arrived)", $time, outstanding);
            drain_fail++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIMEOUT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [TIMEOUT_W-1:0] tmo, input logic [PERIOD_W-1:0] per,
                             input int count, input int hold_at, input int pause_at);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_PERIOD, TIMEOUT_W'(per));
        @(negedge clk);
        cfg_we <= 1'b0;
        setting_count++;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                rx_hold = 1'b1;
            if (n == pause_at)
                drain();
            send_random();
        end
        drain();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_TICK;
        cfg_we        = 1'b0;
        cfg_index     = CFG_TIMEOUT;
        cfg_wdata     = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_hold       = 1'b0;
        sent_count    = 0;
        drain_fail    = 0;
        setting_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings; no tick yet, so the scan countdown is still zero
        send_item(OP_FAULT, 8'h00, 8'hFF);
        send_item(OP_FAULT, 8'hFF, 8'h00);
        send_item(OP_CLEAR, 8'hAA, 8'h55);
        send_item(OP_BEAT, 8'(NCH), 8'hFF);
        send_item(OP_BEAT, 8'hFF, 8'h00);
        send_item(OP_BEAT, 8'h00, 8'hA5);
        drain();

        // zero timeout and zero period; spare indexes must have no effect
        write_reg(CFG_TIMEOUT, '0);
        write_reg(CFG_PERIOD, '0);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, TIMEOUT_W'(3));
        @(negedge clk);
        cfg_we <= 1'b0;
        setting_count++;
        send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_BEAT, 8'd2, 8'h00);
        send_item(OP_BEAT, 8'd1, 8'hFF);
        send_item(OP_BEAT, 8'(NCH - 1), 8'h00);
        send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_TICK, 8'hFF, 8'hFF);
        send_item(OP_BEAT, 8'(NCH - 1), 8'h3C);
        send_item(OP_CLEAR, 8'hFF, 8'hFF);
        send_item(OP_TICK, 8'h5A, 8'hC3);
        send_item(OP_BEAT, 8'h00, 8'h00);
        send_item(OP_FAULT, 8'h00, 8'h81);
        send_item(OP_TICK, 8'h00, 8'h00);
        drain();

        run_phase(TIMEOUT_RESET, PERIOD_RESET, 150, -1, -1);
        run_phase(TIMEOUT_W'(1), PERIOD_W'(1), 250, 30, -1);
        run_phase(TIMEOUT_W'(3), PERIOD_W'(2), 250, -1, 120);
        run_phase(TIMEOUT_W'(1000000), PERIOD_W'(1), 60, -1, -1);
        run_phase(TIMEOUT_W'($urandom_range(2, 30)), PERIOD_W'($urandom_range(1, 6)),
                  250, -1, -1);
        run_phase(TIMEOUT_W'($urandom_range(0, 10)), PERIOD_W'($urandom_range(0, 3)),
                  250, -1, -1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_phase(TIMEOUT_W'(6), PERIOD_W'(3), 200, -1, -1);
        // all-ones settings last: the long reload would starve later scans
        run_phase('1, '1, 100, -1, -1);

        $display("Sent %0d ticks, beats, fault reports and history clears over %0d settings",
                 sent_count, setting_count);
        $display("Run included a %0d-cycle output hold and a mid-phase full drain", HOLD_CYCLES);
        if (errors == 0 && drain_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/hbw_pkg.sv
rtl/hbw_beat_mem.sv
rtl/hbw_core.sv
rtl/multi_channel_heartbeat_watchdog.sv
tb/hbw_checker.sv
tb/tb.sv
